// ----- hdl/mctc_pkg.sv -----
package mctc_pkg;

  // playlist size limit and the wrap cap that follows from it
  localparam int MaxTracks = 32;
  localparam int TrackCap  = (MaxTracks < 32) ? MaxTracks : 32;

  // result action codes
  typedef enum logic [2:0] {
    ACT_NONE   = 3'd0,
    ACT_PAUSED = 3'd1,
    ACT_RESUME = 3'd2,
    ACT_NEXT   = 3'd3,
    ACT_PREV   = 3'd4
  } action_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_CLICK_TIMEOUT = 2'd0,
    CFG_DEBOUNCE      = 2'd1,
    CFG_SONG_COUNT    = 2'd2,
    CFG_VISIBLE_LINES = 2'd3
  } cfg_index_t;

  // register reset values
  localparam logic [15:0] ClickTimeoutReset = 16'd400;
  localparam logic [7:0]  DebounceReset     = 8'd20;
  localparam logic [5:0]  SongCountReset    = 6'd0;
  localparam logic [3:0]  VisibleLinesReset = 4'd4;

  typedef struct packed {
    logic [15:0] click_timeout_ms;
    logic [7:0]  debounce_ms;
    logic [5:0]  song_count;
    logic [3:0]  visible_lines;
  } cfg_t;

  typedef struct packed {
    logic        button_held;
    logic [1:0]  clicks_seen;
    logic [15:0] ms_since_press;
    logic [7:0]  lockout_left;
    logic        paused;
    logic [4:0]  track_index;
    logic [4:0]  window_first;
  } state_t;

  typedef struct packed {
    logic button_level;
    logic track_loaded;
    logic track_ended;
  } tick_t;

  typedef struct packed {
    action_t    action;
    logic       paused_flag;
    logic [4:0] track_number;
    logic [4:0] first_visible;
  } result_t;

  // wrap limit: song count capped at the playlist size
  function automatic logic [5:0] track_limit(input logic [5:0] song_count);
    logic [5:0] lim;
    lim = song_count;
    if (song_count > 6'(TrackCap)) lim = 6'(TrackCap);
    return lim;
  endfunction

  // one step forward or back with wraparound
  function automatic logic [4:0] move_track(input logic [4:0] idx, input logic prev,
                                            input logic [5:0] lim);
    logic [5:0] up;
    logic [5:0] down;
    logic [5:0] n;
    up   = {1'b0, idx} + 6'd1;
    down = {1'b0, idx} - 6'd1;
    if (!prev) begin
      n = (up >= lim) ? 6'd0 : up;
    end else if (idx == 5'd0) begin
      n = (lim != 6'd0) ? lim - 6'd1 : 6'd0;
    end else begin
      n = (down >= lim) ? 6'd0 : down;
    end
    return n[4:0];
  endfunction

endpackage

// ----- hdl/mctc_if.sv -----
// tick channel
interface mctc_tick_if;
  logic valid;
  logic ready;
  logic button_level;
  logic track_loaded;
  logic track_ended;
  modport source(output valid, output button_level, output track_loaded,
                 output track_ended, input ready);
  modport sink(input valid, input button_level, input track_loaded,
               input track_ended, output ready);
endinterface

// result channel
interface mctc_result_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic       paused_flag;
  logic [4:0] track_number;
  logic [4:0] first_visible;
  modport source(output valid, output action, output paused_flag,
                 output track_number, output first_visible, input ready);
  modport sink(input valid, input action, input paused_flag,
               input track_number, input first_visible, output ready);
endinterface

// configuration write channel
interface mctc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

// ----- hdl/mctc_step.sv -----
module mctc_step (
  input  mctc_pkg::state_t  st,
  input  mctc_pkg::tick_t   tk,
  input  mctc_pkg::cfg_t    cfg,
  output mctc_pkg::state_t  st_next,
  output mctc_pkg::result_t res
);

  logic       pressed;
  logic       decide;
  logic       skip;
  logic       skip_prev;
  logic [5:0] lim;
  logic [3:0] lines;
  mctc_pkg::action_t action;

  always_comb begin
    st_next   = st;
    pressed   = 1'b0;
    skip      = 1'b0;
    skip_prev = 1'b0;
    action    = mctc_pkg::ACT_NONE;
    lim       = mctc_pkg::track_limit(cfg.song_count);
    lines     = (cfg.visible_lines == 4'd0) ? 4'd1 : cfg.visible_lines;

    // debounce lockout and edge detection
    if (st.lockout_left != 8'd0) begin
      st_next.lockout_left = st.lockout_left - 8'd1;
    end else if (tk.button_level && !st.button_held) begin
      st_next.button_held  = 1'b1;
      if (st.clicks_seen != 2'd3) st_next.clicks_seen = st.clicks_seen + 2'd1;
      pressed              = 1'b1;
      st_next.lockout_left = cfg.debounce_ms;
    end else if (!tk.button_level && st.button_held) begin
      st_next.button_held  = 1'b0;
      st_next.lockout_left = cfg.debounce_ms;
    end

    // time since last press, saturating
    if (pressed) begin
      st_next.ms_since_press = 16'd0;
    end else if (st.ms_since_press != 16'hFFFF) begin
      st_next.ms_since_press = st.ms_since_press + 16'd1;
    end

    // click decision once the gap exceeds the timeout
    decide = (st_next.clicks_seen != 2'd0) &&
             (st_next.ms_since_press > cfg.click_timeout_ms);
    if (decide) begin
      if (tk.track_loaded) begin
        case (st_next.clicks_seen)
          2'd1: begin
            st_next.paused = ~st.paused;
            action = st.paused ? mctc_pkg::ACT_RESUME : mctc_pkg::ACT_PAUSED;
          end
          2'd2: begin
            st_next.paused = 1'b0;
            skip   = 1'b1;
            action = mctc_pkg::ACT_NEXT;
          end
          default: begin
            st_next.paused = 1'b0;
            skip      = 1'b1;
            skip_prev = 1'b1;
            action    = mctc_pkg::ACT_PREV;
          end
        endcase
      end
      st_next.clicks_seen = 2'd0;
    end

    // one index move per tick: skip wins over track end
    if (skip || tk.track_ended) begin
      st_next.track_index = mctc_pkg::move_track(st.track_index, skip_prev, lim);
    end

    // window start follows the index
    if (lim != 6'd0) begin
      if (st_next.track_index < st.window_first) begin
        st_next.window_first = st_next.track_index;
      end else if ({1'b0, st_next.track_index} >=
                   ({1'b0, st.window_first} + {2'b00, lines})) begin
        st_next.window_first = st_next.track_index - {1'b0, lines} + 5'd1;
      end
    end

    res.action        = action;
    res.paused_flag   = st_next.paused;
    res.track_number  = st_next.track_index;
    res.first_visible = st_next.window_first;
  end

endmodule

// ----- hdl/multi_click_track_control.sv -----
// result: a tick transaction shows its result in the cycle after acceptance
// throughput: one tick per cycle while the result slot is free or drained, set by the
//   single state update between the state registers and the result register
// reset: rst (synchronous) restores register defaults, clears button and
//   click state, pause, track index and window start, and empties the result
module multi_click_track_control (
  input  logic                 clk,
  input  logic                 rst,
  mctc_tick_if.sink            tick,
  mctc_result_if.source        result,
  mctc_cfg_if.sink             cfg
);

  mctc_pkg::cfg_t    cfg_reg;
  mctc_pkg::state_t  st;
  mctc_pkg::state_t  st_next;
  mctc_pkg::tick_t   tk;
  mctc_pkg::result_t res_next;
  mctc_pkg::result_t res;
  logic              out_valid;
  logic              in_acc;

  // configuration writes always taken
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_reg.click_timeout_ms <= mctc_pkg::ClickTimeoutReset;
      cfg_reg.debounce_ms      <= mctc_pkg::DebounceReset;
      cfg_reg.song_count       <= mctc_pkg::SongCountReset;
      cfg_reg.visible_lines    <= mctc_pkg::VisibleLinesReset;
    end else if (cfg.valid) begin
      unique case (mctc_pkg::cfg_index_t'(cfg.index))
        mctc_pkg::CFG_CLICK_TIMEOUT: cfg_reg.click_timeout_ms <= cfg.data;
        mctc_pkg::CFG_DEBOUNCE:      cfg_reg.debounce_ms      <= cfg.data[7:0];
        mctc_pkg::CFG_SONG_COUNT:    cfg_reg.song_count       <= cfg.data[5:0];
        mctc_pkg::CFG_VISIBLE_LINES: cfg_reg.visible_lines    <= cfg.data[3:0];
        default: ;
      endcase
    end
  end

  // take a tick whenever the result slot is free or being drained
  assign tick.ready = !out_valid || result.ready;
  assign in_acc     = tick.valid && tick.ready;

  assign tk.button_level = tick.button_level;
  assign tk.track_loaded = tick.track_loaded;
  assign tk.track_ended  = tick.track_ended;

  mctc_step u_step (
    .st      (st),
    .tk      (tk),
    .cfg     (cfg_reg),
    .st_next (st_next),
    .res     (res_next)
  );

  // state update per accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (in_acc) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_acc) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) res <= res_next;
  end

  assign result.valid         = out_valid;
  assign result.action        = res.action;
  assign result.paused_flag   = res.paused_flag;
  assign result.track_number  = res.track_number;
  assign result.first_visible = res.first_visible;

  // pause action agrees with the reported pause state
  a_pause_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid && (res.action == mctc_pkg::ACT_PAUSED) |-> res.paused_flag)
    else $error("paused action without pause flag");

  // resume and skips always leave pause cleared
  a_unpaused: assert property (@(posedge clk) disable iff (rst)
    out_valid && ((res.action == mctc_pkg::ACT_RESUME) ||
                  (res.action == mctc_pkg::ACT_NEXT) ||
                  (res.action == mctc_pkg::ACT_PREV)) |-> !res.paused_flag)
    else $error("pause still set after resume or skip");

  // lockout counts down by one per accepted tick
  a_lockout: assert property (@(posedge clk) disable iff (rst)
    in_acc && (st.lockout_left != 8'd0) |=>
      (st.lockout_left == $past(st.lockout_left) - 8'd1))
    else $error("lockout did not count down");

  // window start never passes the index once a playlist exists
  a_window: assert property (@(posedge clk) disable iff (rst)
    $past(in_acc && !rst && (mctc_pkg::track_limit(cfg_reg.song_count) != 6'd0))
      |-> (st.track_index >= st.window_first))
    else $error("window start beyond track index");

  // result slot is not overwritten while stalled
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    out_valid && !result.ready |-> !in_acc)
    else $error("tick accepted over a pending result");

endmodule
